### hdl/rc5tx_pkg.sv
// Shared types and constants for the RC5 IR frame transmitter.
`timescale 1ns / 1ps
package rc5tx_pkg;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_FRAME = 4'b0010,
		PH_TRAIL = 4'b0100,
		PH_GAP   = 4'b1000
	} phase_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SEND = 1'b1
	} op_t;

	localparam logic [2:0] REG_SENDER_MODE = 3'd0;
	localparam logic [2:0] REG_MARK_TICKS  = 3'd1;
	localparam logic [2:0] REG_SPACE_TICKS = 3'd2;
	localparam logic [2:0] REG_GAP_TICKS   = 3'd3;

	localparam logic [2:0]  SENDER_MODE_RST = 3'd0;
	localparam logic [7:0]  MARK_TICKS_RST  = 8'd32;
	localparam logic [7:0]  SPACE_TICKS_RST = 8'd32;
	localparam logic [15:0] GAP_TICKS_RST   = 16'd3204;

	localparam logic [3:0] FRAME_LEN  = 4'd14;
	localparam logic [3:0] FRAME_LAST = 4'd13;

	typedef struct packed {
		op_t        op;
		logic [4:0] address;
		logic [5:0] command;
		logic       toggle;
		logic [2:0] required_mode;
		logic [3:0] repeats;
	} item_t;

	typedef struct packed {
		logic [2:0]  sender_mode;
		logic [7:0]  mark_ticks;
		logic [7:0]  space_ticks;
		logic [15:0] gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic carrier_on;
		logic busy;
		logic accepted;
		logic done;
	} result_t;

endpackage

### hdl/rc5tx_queue.sv
// Front end: takes input words, classifies the opcode and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module rc5tx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_op,
	input  logic [4:0]         in_address,
	input  logic [5:0]         in_command,
	input  logic               in_toggle,
	input  logic [2:0]         in_required_mode,
	input  logic [3:0]         in_repeats,
	output logic               out_valid,
	input  logic               out_ready,
	output rc5tx_pkg::item_t   out_item
);

	rc5tx_pkg::item_t slot_q [2];
	rc5tx_pkg::item_t in_item;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	always_comb begin
		in_item.op            = in_op ? rc5tx_pkg::OP_SEND : rc5tx_pkg::OP_TICK;
		in_item.address       = in_address;
		in_item.command       = in_command;
		in_item.toggle        = in_toggle;
		in_item.required_mode = in_required_mode;
		in_item.repeats       = in_repeats;
	end

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hdl/rc5tx_back.sv
// Back end: frame sequencer, one queued word per cycle to an output register unless stalled.
`timescale 1ns / 1ps
module rc5tx_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rc5tx_pkg::cfg_t     cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  rc5tx_pkg::item_t    item,
	output logic                res_valid,
	input  logic                res_ready,
	output rc5tx_pkg::result_t  res
);

	rc5tx_pkg::phase_t  phase_q,  phase_n;
	logic [13:0]        frame_q,  frame_n;
	logic [3:0]         bit_q,    bit_n;
	logic               half_q,   half_n;
	logic [15:0]        count_q,  count_n;
	logic [3:0]         rep_q,    rep_n;
	rc5tx_pkg::result_t res_q,    res_n;
	logic               res_valid_q;

	logic        take;
	logic        cur_bit;
	logic        mark;
	logic [15:0] len;
	logic [15:0] count_inc;
	logic [3:0]  bit_inc;
	logic [3:0]  rep_dec;

	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	assign take       = item_valid && (!res_valid_q || res_ready);
	assign item_ready = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		phase_n   = phase_q;
		frame_n   = frame_q;
		bit_n     = bit_q;
		half_n    = half_q;
		count_n   = count_q;
		rep_n     = rep_q;
		res_n     = '0;
		cur_bit   = (bit_q <= rc5tx_pkg::FRAME_LAST) ?
			frame_q[rc5tx_pkg::FRAME_LAST - bit_q] : 1'b0;
		mark      = ~(cur_bit ^ half_q);
		count_inc = count_q + 16'd1;
		bit_inc   = bit_q + 4'd1;
		rep_dec   = rep_q - 4'd1;
		len       = 16'd1;

		unique case (phase_q)
			rc5tx_pkg::PH_FRAME: len = at_least_one({8'd0, mark ? cfg.mark_ticks : cfg.space_ticks});
			rc5tx_pkg::PH_TRAIL: len = at_least_one({8'd0, cfg.space_ticks});
			rc5tx_pkg::PH_GAP:   len = at_least_one(cfg.gap_ticks);
			default:             len = 16'd1;
		endcase

		if (item.op == rc5tx_pkg::OP_SEND) begin
			if (phase_q == rc5tx_pkg::PH_IDLE && cfg.sender_mode >= item.required_mode) begin
				res_n.accepted = 1'b1;
				if (item.repeats != 4'd0) begin
					frame_n = {2'b11, item.toggle, item.address, item.command};
					rep_n   = item.repeats;
					phase_n = rc5tx_pkg::PH_FRAME;
					bit_n   = 4'd0;
					half_n  = 1'b0;
					count_n = 16'd0;
				end
			end
			res_n.busy = (phase_n != rc5tx_pkg::PH_IDLE);
		end else if (phase_q != rc5tx_pkg::PH_IDLE) begin
			res_n.busy       = 1'b1;
			res_n.carrier_on = (phase_q == rc5tx_pkg::PH_FRAME) && mark;
			if (count_inc >= len) begin
				count_n = 16'd0;
				unique case (phase_q)
					rc5tx_pkg::PH_FRAME: begin
						if (!half_q) begin
							half_n = 1'b1;
						end else begin
							half_n = 1'b0;
							if (bit_inc >= rc5tx_pkg::FRAME_LEN) begin
								bit_n   = 4'd0;
								phase_n = rc5tx_pkg::PH_TRAIL;
							end else begin
								bit_n = bit_inc;
							end
						end
					end
					rc5tx_pkg::PH_TRAIL: begin
						rep_n = rep_dec;
						if (rep_dec == 4'd0) begin
							phase_n    = rc5tx_pkg::PH_IDLE;
							res_n.done = 1'b1;
						end else if (cfg.gap_ticks == 16'd0) begin
							phase_n = rc5tx_pkg::PH_FRAME;
							bit_n   = 4'd0;
							half_n  = 1'b0;
						end else begin
							phase_n = rc5tx_pkg::PH_GAP;
						end
					end
					default: begin
						phase_n = rc5tx_pkg::PH_FRAME;
						bit_n   = 4'd0;
						half_n  = 1'b0;
					end
				endcase
			end else begin
				count_n = count_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rc5tx_pkg::PH_IDLE;
			frame_q     <= '0;
			bit_q       <= '0;
			half_q      <= 1'b0;
			count_q     <= '0;
			rep_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_n;
				frame_q <= frame_n;
				bit_q   <= bit_n;
				half_q  <= half_n;
				count_q <= count_n;
				rep_q   <= rep_n;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_n;
		end
	end

endmodule

### hdl/rc5_ir_frame_transmitter.sv
// Top level of the RC5 IR frame transmitter: configuration registers, front queue and sequencer.
// Each input word is either one carrier-period tick or a send request, and each yields exactly
// one result word. Sustained rate is one word per clock while out_ready is high: words pass
// through a two-entry queue into a sequencer that computes the next frame state combinationally
// and holds the result in an output register, written as the word leaves the queue.
// While out_ready is low the output register and the queue hold up to three words before
// in_ready drops. Configuration writes are taken every cycle (cfg_ready is always high);
// unknown indexes are ignored.
`timescale 1ns / 1ps
module rc5_ir_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [4:0]  address,
	input  logic [5:0]  command,
	input  logic        toggle,
	input  logic [2:0]  required_mode,
	input  logic [3:0]  repeats,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        carrier_on,
	output logic        busy_res,
	output logic        accepted,
	output logic        done_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rc5tx_pkg::cfg_t    cfg_q;
	rc5tx_pkg::item_t   q_item;
	rc5tx_pkg::result_t res;
	logic               q_valid;
	logic               q_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sender_mode <= rc5tx_pkg::SENDER_MODE_RST;
			cfg_q.mark_ticks  <= rc5tx_pkg::MARK_TICKS_RST;
			cfg_q.space_ticks <= rc5tx_pkg::SPACE_TICKS_RST;
			cfg_q.gap_ticks   <= rc5tx_pkg::GAP_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rc5tx_pkg::REG_SENDER_MODE: cfg_q.sender_mode <= cfg_data[2:0];
				rc5tx_pkg::REG_MARK_TICKS:  cfg_q.mark_ticks  <= cfg_data[7:0];
				rc5tx_pkg::REG_SPACE_TICKS: cfg_q.space_ticks <= cfg_data[7:0];
				rc5tx_pkg::REG_GAP_TICKS:   cfg_q.gap_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	rc5tx_queue u_queue (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_op            (op),
		.in_address       (address),
		.in_command       (command),
		.in_toggle        (toggle),
		.in_required_mode (required_mode),
		.in_repeats       (repeats),
		.out_valid        (q_valid),
		.out_ready        (q_ready),
		.out_item         (q_item)
	);

	rc5tx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign carrier_on = res.carrier_on;
	assign busy_res   = res.busy;
	assign accepted   = res.accepted;
	assign done_res   = res.done;

	// a word is either a tick result or a request result, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && (done_res || carrier_on)))
		else $error("request result carries tick outputs");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (carrier_on || done_res) |-> busy_res)
		else $error("carrier or done outside a sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !carrier_on)
		else $error("carrier on during trailing space");

endmodule
